>>> rtl/esm_pkg.sv
package esm_pkg;

   localparam int PULSES_PER_REV_DEF = 7;
   localparam int COUNT_BITS_DEF     = 16;

   localparam int WINDOW_BITS = 16;
   localparam int DRIVE_BITS  = 8;
   localparam int GAIN_BITS   = 8;
   localparam int SPEED_BITS  = 24;
   localparam int CSR_BITS    = 3;
   localparam int WDATA_BITS  = 16;

   // rpm with 4 fraction bits: 60 * 16
   localparam int RPM_SCALE  = 960;
   localparam int GAIN_SCALE = 60;
   // gain has 8 fraction bits
   localparam int GAIN_FRAC  = 8;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd1000;
   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 8'd128;
   localparam logic [DRIVE_BITS-1:0]  MIN_RESET    = 8'd150;
   localparam logic [DRIVE_BITS-1:0]  MAX_RESET    = 8'd255;
   localparam logic [DRIVE_BITS-1:0]  REF_RESET    = 8'd170;

   localparam logic [CSR_BITS-1:0] CSR_WINDOW = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_GAIN   = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_MIN    = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_MAX    = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_REF    = 3'd4;

   typedef struct packed {
      logic edge_a;
      logic edge_b;
      logic ms_tick;
   } req_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] speed_a;
      logic [SPEED_BITS-1:0] speed_b;
      logic [DRIVE_BITS-1:0] drive_a;
      logic [DRIVE_BITS-1:0] drive_b;
   } rsp_type;

   typedef struct packed {
      logic [WINDOW_BITS-1:0] window_ms;
      logic [GAIN_BITS-1:0]   gain_q8;
      logic [DRIVE_BITS-1:0]  min_drive;
      logic [DRIVE_BITS-1:0]  max_drive;
      logic [DRIVE_BITS-1:0]  ref_drive;
   } cfg_type;

endpackage

>>> rtl/esm_count.sv
module esm_count #(
   parameter int COUNT_BITS = esm_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  esm_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  esm_pkg::req_type      req_data,
   output logic                  win_valid,
   input  logic                  win_ready,
   output logic [COUNT_BITS-1:0] win_a,
   output logic [COUNT_BITS-1:0] win_b
);

   localparam int WB = esm_pkg::WINDOW_BITS;

   logic [COUNT_BITS-1:0] cnt_a_ff, cnt_b_ff;
   logic [COUNT_BITS-1:0] cnt_a_in, cnt_b_in;
   logic [WB-1:0]         elapsed_ff, elapsed_in;
   logic [WB-1:0]         win_len;
   logic [COUNT_BITS-1:0] win_a_ff, win_b_ff;
   logic                  win_valid_ff;
   logic                  accept, close;

   assign req_ready = !win_valid_ff || win_ready;
   assign accept    = req_valid && req_ready;

   // saturating counts, including this word's edges and tick
   assign cnt_a_in = cnt_a_ff + COUNT_BITS'(req_data.edge_a && (cnt_a_ff != '1));
   assign cnt_b_in = cnt_b_ff + COUNT_BITS'(req_data.edge_b && (cnt_b_ff != '1));
   assign elapsed_in = elapsed_ff + WB'(req_data.ms_tick && (elapsed_ff != '1));

   // zero window acts as one
   assign win_len = (cfg.window_ms == '0) ? WB'(1) : cfg.window_ms;
   assign close   = elapsed_in >= win_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         elapsed_ff   <= '0;
         win_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (close) begin
               cnt_a_ff   <= '0;
               cnt_b_ff   <= '0;
               elapsed_ff <= '0;
            end else begin
               cnt_a_ff   <= cnt_a_in;
               cnt_b_ff   <= cnt_b_in;
               elapsed_ff <= elapsed_in;
            end
         end
         if (accept && close) begin
            win_valid_ff <= 1'b1;
         end else if (win_ready) begin
            win_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && close) begin
         win_a_ff <= cnt_a_in;
         win_b_ff <= cnt_b_in;
      end
   end

   assign win_valid = win_valid_ff;
   assign win_a     = win_a_ff;
   assign win_b     = win_b_ff;

   a_clear_on_close: assert property (@(posedge clock) disable iff (reset)
      accept && close |=> cnt_a_ff == '0 && cnt_b_ff == '0 && elapsed_ff == '0)
      else $error("counters not cleared at window end");

endmodule

>>> rtl/esm_scale.sv
module esm_scale #(
   parameter int PULSES_PER_REV = esm_pkg::PULSES_PER_REV_DEF,
   parameter int COUNT_BITS     = esm_pkg::COUNT_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  esm_pkg::cfg_type                       cfg,
   input  logic                                   win_valid,
   output logic                                   win_ready,
   input  logic [COUNT_BITS-1:0]                  win_a,
   input  logic [COUNT_BITS-1:0]                  win_b,
   output logic                                   corr_valid,
   input  logic                                   corr_ready,
   output logic [esm_pkg::SPEED_BITS-1:0]         corr_speed_a,
   output logic [esm_pkg::SPEED_BITS-1:0]         corr_speed_b,
   output logic                                   corr_neg,
   output logic [COUNT_BITS+5:0]                  corr_mag
);

   localparam int D    = PULSES_PER_REV;
   localparam int LD   = $clog2(D);
   // pulses * 960
   localparam int XW   = COUNT_BITS + 10;
   // gain * 60 * diff, then >> 8
   localparam int G60W = esm_pkg::GAIN_BITS + 6;
   localparam int PW   = COUNT_BITS + G60W;
   localparam int HW   = PW - esm_pkg::GAIN_FRAC;
   // divide by D as multiply by ceil(2^S / D), exact for XW/HW-bit inputs
   localparam int SX   = XW + LD;
   localparam int SH   = HW + LD;
   localparam logic [XW:0] MX = (XW+1)'(((64'd1 << SX) + 64'(D) - 64'd1) / 64'(D));
   localparam logic [HW:0] MH = (HW+1)'(((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D));
   localparam int RXW  = SX + XW;
   localparam int RHW  = SH + HW;

   // stage 2
   logic                  s2_valid_ff;
   logic [XW-1:0]         xa_ff, xb_ff;
   logic [HW-1:0]         ph_ff;
   logic                  s2_neg_ff;
   logic                  s2_free;

   // stage 3
   logic                          s3_valid_ff;
   logic [esm_pkg::SPEED_BITS-1:0] speed_a_ff, speed_b_ff;
   logic [HW-1:0]                 mag_ff;
   logic                          s3_neg_ff;
   logic                          s3_free;

   logic                  neg;
   logic [COUNT_BITS-1:0] diff;
   logic [G60W-1:0]       gain60;
   logic [PW-1:0]         prod_g;
   logic [RXW-1:0]        prod_a, prod_b;
   logic [RHW-1:0]        prod_h;

   assign s3_free   = !s3_valid_ff || corr_ready;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign win_ready = s2_free;

   assign neg    = win_b > win_a;
   assign diff   = neg ? (win_b - win_a) : (win_a - win_b);
   assign gain60 = G60W'(cfg.gain_q8) * G60W'(esm_pkg::GAIN_SCALE);
   assign prod_g = PW'(gain60) * PW'(diff);

   assign prod_a = RXW'(xa_ff) * RXW'(MX);
   assign prod_b = RXW'(xb_ff) * RXW'(MX);
   assign prod_h = RHW'(ph_ff) * RHW'(MH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_free) begin
            s2_valid_ff <= win_valid;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && win_valid) begin
         xa_ff     <= XW'(win_a) * XW'(esm_pkg::RPM_SCALE);
         xb_ff     <= XW'(win_b) * XW'(esm_pkg::RPM_SCALE);
         ph_ff     <= prod_g[PW-1:esm_pkg::GAIN_FRAC];
         s2_neg_ff <= neg;
      end
      if (s3_free && s2_valid_ff) begin
         speed_a_ff <= esm_pkg::SPEED_BITS'(prod_a[SX +: XW]);
         speed_b_ff <= esm_pkg::SPEED_BITS'(prod_b[SX +: XW]);
         mag_ff     <= prod_h[SH +: HW];
         s3_neg_ff  <= s2_neg_ff;
      end
   end

   assign corr_valid   = s3_valid_ff;
   assign corr_speed_a = speed_a_ff;
   assign corr_speed_b = speed_b_ff;
   assign corr_neg     = s3_neg_ff;
   assign corr_mag     = mag_ff;

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_free |=> s2_valid_ff && $stable(ph_ff) && $stable(xa_ff))
      else $error("stage 2 lost a stalled window");

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !corr_ready |=> s3_valid_ff && $stable(mag_ff))
      else $error("stage 3 lost a stalled window");

endmodule

>>> rtl/esm_drive.sv
module esm_drive #(
   parameter int COUNT_BITS = esm_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  esm_pkg::cfg_type               cfg,
   input  logic                           corr_valid,
   output logic                           corr_ready,
   input  logic [esm_pkg::SPEED_BITS-1:0] corr_speed_a,
   input  logic [esm_pkg::SPEED_BITS-1:0] corr_speed_b,
   input  logic                           corr_neg,
   input  logic [COUNT_BITS+5:0]          corr_mag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output esm_pkg::rsp_type               rsp_data
);

   localparam int DB = esm_pkg::DRIVE_BITS;
   // drive plus or minus the magnitude, with sign
   localparam int W  = COUNT_BITS + 8;

   logic                 rsp_valid_ff;
   esm_pkg::rsp_type     rsp_data_ff;
   logic [DB-1:0]        drive_b_ff, drive_b_in;
   logic signed [W-1:0]  base, mag, sum, lo, hi;
   logic                 load;

   assign corr_ready = !rsp_valid_ff || rsp_ready;
   assign load       = corr_valid && corr_ready;

   assign base = signed'(W'(drive_b_ff));
   assign mag  = signed'(W'(corr_mag));
   assign sum  = corr_neg ? (base - mag) : (base + mag);
   assign lo   = signed'(W'(cfg.min_drive));
   assign hi   = signed'(W'(cfg.max_drive));

   // min check wins when the limits cross
   always_comb begin
      priority if (sum < lo) begin
         drive_b_in = cfg.min_drive;
      end else if (sum > hi) begin
         drive_b_in = cfg.max_drive;
      end else begin
         drive_b_in = DB'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         drive_b_ff   <= esm_pkg::REF_RESET;
      end else begin
         if (corr_ready) begin
            rsp_valid_ff <= corr_valid;
         end
         if (load) begin
            drive_b_ff <= drive_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.speed_a <= corr_speed_a;
         rsp_data_ff.speed_b <= corr_speed_b;
         rsp_data_ff.drive_a <= cfg.ref_drive;
         rsp_data_ff.drive_b <= drive_b_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_drive_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.drive_b == drive_b_ff)
      else $error("output drive differs from held drive");

endmodule

>>> rtl/encoder_speed_match_p_loop.sv
// Channel  Ports                               Direction  Moves
// req      req_valid req_ready req_data        in         edge/tick word per slice
// rsp      rsp_valid rsp_ready rsp_data        out        speeds and drives per window
// csr      csr_valid csr_ready csr_index/wdata in         register write, always ready
//
// One req word per cycle while req_ready is high; pulse counting and the window check happen at accept.
// A window-closing word yields its rsp word through registers: the window register,
// product stage, reciprocal-multiply stage (divide by pulses per rev), then the drive clamp.
// Reset clears counters and valids and sets drive B to 170; registers to defaults.
// rsp stalls back up through the stages; req_ready drops only when all are full.
module encoder_speed_match_p_loop #(
   parameter int PULSES_PER_REV = esm_pkg::PULSES_PER_REV_DEF,
   parameter int COUNT_BITS     = esm_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  esm_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output esm_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [esm_pkg::CSR_BITS-1:0]   csr_index,
   input  logic [esm_pkg::WDATA_BITS-1:0] csr_wdata
);

   localparam int DB = esm_pkg::DRIVE_BITS;

   esm_pkg::cfg_type cfg_ff;

   logic                           win_valid, win_ready;
   logic [COUNT_BITS-1:0]          win_a, win_b;
   logic                           corr_valid, corr_ready, corr_neg;
   logic [esm_pkg::SPEED_BITS-1:0] corr_speed_a, corr_speed_b;
   logic [COUNT_BITS+5:0]          corr_mag;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms <= esm_pkg::WINDOW_RESET;
         cfg_ff.gain_q8   <= esm_pkg::GAIN_RESET;
         cfg_ff.min_drive <= esm_pkg::MIN_RESET;
         cfg_ff.max_drive <= esm_pkg::MAX_RESET;
         cfg_ff.ref_drive <= esm_pkg::REF_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            esm_pkg::CSR_WINDOW: cfg_ff.window_ms <= csr_wdata;
            esm_pkg::CSR_GAIN:   cfg_ff.gain_q8   <= esm_pkg::GAIN_BITS'(csr_wdata);
            esm_pkg::CSR_MIN:    cfg_ff.min_drive <= DB'(csr_wdata);
            esm_pkg::CSR_MAX:    cfg_ff.max_drive <= DB'(csr_wdata);
            esm_pkg::CSR_REF:    cfg_ff.ref_drive <= DB'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   esm_count #(
      .COUNT_BITS(COUNT_BITS)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .win_a     (win_a),
      .win_b     (win_b)
   );

   esm_scale #(
      .PULSES_PER_REV(PULSES_PER_REV),
      .COUNT_BITS    (COUNT_BITS)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .win_valid    (win_valid),
      .win_ready    (win_ready),
      .win_a        (win_a),
      .win_b        (win_b),
      .corr_valid   (corr_valid),
      .corr_ready   (corr_ready),
      .corr_speed_a (corr_speed_a),
      .corr_speed_b (corr_speed_b),
      .corr_neg     (corr_neg),
      .corr_mag     (corr_mag)
   );

   esm_drive #(
      .COUNT_BITS(COUNT_BITS)
   ) u_drive (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .corr_valid   (corr_valid),
      .corr_ready   (corr_ready),
      .corr_speed_a (corr_speed_a),
      .corr_speed_b (corr_speed_b),
      .corr_neg     (corr_neg),
      .corr_mag     (corr_mag),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
